// ----- rtl/float32_to_half_pair_pack_defines.svh -----
// assertion macros used by the checker file
`ifndef FLOAT32_TO_HALF_PAIR_PACK_DEFINES_SVH
`define FLOAT32_TO_HALF_PAIR_PACK_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define F2HPP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("f2hpp check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define F2HPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("f2hpp check failed");

`endif

// ----- rtl/f2hpp_pkg.sv -----
// constants and widths for the single-to-half pair packer
package f2hpp_pkg;

  localparam int unsigned F32_W  = 32;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned PACK_W = 2 * HALF_W;

  localparam logic [7:0]  F32_EXP_SPECIAL = 8'hFF;
  // binary32 exponent for half exponent 0 is 112, for 31 is 143
  localparam logic [7:0]  HALF_EXP_OFFSET = 8'd112;
  localparam logic [7:0]  SUB_SHIFT_BASE  = 8'd113;
  localparam logic [7:0]  SUB_MIN_EXP     = 8'd102;
  localparam logic [7:0]  OVF_MIN_EXP     = 8'd143;

  localparam logic [23:0] ROUND_HALF_ULP  = 24'h001000;
  localparam logic [9:0]  HALF_MANT_MAX   = 10'h3FF;
  localparam logic [4:0]  HALF_EXP_MAX    = 5'd30;
  localparam logic [14:0] HALF_INF_MAG    = 15'h7C00;
  localparam logic [15:0] HALF_NAN_CODE   = 16'h7FFF;

endpackage

// ----- rtl/f2hpp_in_if.sv -----
// input channel: a pair of binary32 patterns with valid/ready
interface f2hpp_in_if
  import f2hpp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [F32_W-1:0]  first_float_bits;
  logic [F32_W-1:0]  second_float_bits;

  modport source (output valid, output first_float_bits, output second_float_bits,
                  input ready);
  modport sink   (input valid, input first_float_bits, input second_float_bits,
                  output ready);
endinterface

// ----- rtl/f2hpp_out_if.sv -----
// output channel: one packed word of two halves with valid/ready
interface f2hpp_out_if
  import f2hpp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PACK_W-1:0] packed_halves;

  modport source (output valid, output packed_halves, input ready);
  modport sink   (input valid, input packed_halves, output ready);
endinterface

// ----- rtl/f2hpp_cvt.sv -----
// binary32 to binary16 conversion, round half up in magnitude
module f2hpp_cvt
  import f2hpp_pkg::*;
(
  input  logic [F32_W-1:0]  single_i,
  output logic [HALF_W-1:0] half_o
);

  logic        sign;
  logic [7:0]  bexp;
  logic [22:0] mant;
  logic [7:0]  sub_shift;
  logic [23:0] sub_sig;
  logic [23:0] sub_sum;
  logic [10:0] sub_rnd;
  logic [9:0]  sub_mant;
  logic [23:0] nrm_sum;
  logic [4:0]  nrm_exp;
  logic [4:0]  nrm_exp_inc;

  always_comb begin
    sign = single_i[31];
    bexp = single_i[30:23];
    mant = single_i[22:0];

    // half subnormal: shift by 1..11 with hidden bit, round, clamp
    sub_shift = SUB_SHIFT_BASE - bexp;
    sub_sig   = {1'b1, mant} >> sub_shift[3:0];
    sub_sum   = sub_sig + ROUND_HALF_ULP;
    sub_rnd   = sub_sum[23:13];
    sub_mant  = sub_rnd[10] ? HALF_MANT_MAX : sub_rnd[9:0];

    // normal range: carry out of rounding bumps the exponent
    nrm_sum     = {1'b0, mant} + ROUND_HALF_ULP;
    nrm_exp     = 5'(bexp - HALF_EXP_OFFSET);
    nrm_exp_inc = nrm_exp + 5'd1;

    if (bexp == F32_EXP_SPECIAL) begin
      half_o = (mant != '0) ? HALF_NAN_CODE : {sign, HALF_INF_MAG};
    end else if (bexp < SUB_MIN_EXP) begin
      half_o = {sign, 15'd0};
    end else if (bexp <= HALF_EXP_OFFSET) begin
      half_o = {sign, 5'd0, sub_mant};
    end else if (bexp >= OVF_MIN_EXP) begin
      half_o = {sign, HALF_INF_MAG};
    end else if (nrm_sum[23]) begin
      half_o = (nrm_exp == HALF_EXP_MAX) ? {sign, HALF_INF_MAG}
                                         : {sign, nrm_exp_inc, 10'd0};
    end else begin
      half_o = {sign, nrm_exp, nrm_sum[22:13]};
    end
  end

endmodule

// ----- rtl/float32_to_half_pair_pack.sv -----
// two-stage packer: input register, two converters, result register
// an input beat passes through the input register, then the two converters into the result register
// throughput: one pair per cycle while out_o.ready is high, set by the two-register pipeline with flow control
// in_i.ready falls only when both registers hold beats and out_o.ready is low
// reset clears both valid flags; the payload registers are not reset
module float32_to_half_pair_pack
  import f2hpp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  f2hpp_in_if.sink      in_i,
  f2hpp_out_if.source   out_o
);

  logic                s1_valid_q;
  logic [F32_W-1:0]    first_q;
  logic [F32_W-1:0]    second_q;
  logic                out_valid_q;
  logic [PACK_W-1:0]   packed_q;
  logic [PACK_W-1:0]   packed_d;
  logic                out_free;
  logic                s1_free;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_free  = !s1_valid_q || out_free;

  assign in_i.ready          = s1_free;
  assign out_o.valid         = out_valid_q;
  assign out_o.packed_halves = packed_q;

  f2hpp_cvt u_cvt_lo (
    .single_i (first_q),
    .half_o   (packed_d[HALF_W-1:0])
  );

  f2hpp_cvt u_cvt_hi (
    .single_i (second_q),
    .half_o   (packed_d[PACK_W-1:HALF_W])
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_i.valid) begin
      first_q  <= in_i.first_float_bits;
      second_q <= in_i.second_float_bits;
    end
    if (out_free && s1_valid_q) begin
      packed_q <= packed_d;
    end
  end

endmodule

// ----- rtl/f2hpp_checker.sv -----
// port-level checks for the pair packer and their bind
`include "float32_to_half_pair_pack_defines.svh"

module f2hpp_checker
  import f2hpp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [PACK_W-1:0] packed_halves_i
);

  logic in_beat;
  logic out_stall;
  logic out_free;
  logic lo_nan;
  logic hi_nan;
  logic nan_code_ok;

  assign in_beat     = in_valid_i && in_ready_i;
  assign out_stall   = out_valid_i && !out_ready_i;
  assign out_free    = !out_valid_i || out_ready_i;
  assign lo_nan      = (packed_halves_i[14:10] == 5'h1F) && (packed_halves_i[9:0] != '0);
  assign hi_nan      = (packed_halves_i[30:26] == 5'h1F) && (packed_halves_i[25:16] != '0);
  assign nan_code_ok = (!lo_nan || packed_halves_i[15:0] == HALF_NAN_CODE) &&
                       (!hi_nan || packed_halves_i[31:16] == HALF_NAN_CODE);

  // a stalled result beat holds
  `F2HPP_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable(packed_halves_i))
  // the input side only stalls when the result side is full and stalled
  `F2HPP_ASSERT_NOW(a_in_ready, out_free, in_ready_i)
  // an accepted beat shows up on the output once out_ready_i has followed the accept
  `F2HPP_ASSERT_NEXT(a_latency, in_beat ##1 out_ready_i, out_valid_i)
  // every NaN half comes out as the single quiet code
  `F2HPP_ASSERT_NOW(a_nan_code, out_valid_i && (lo_nan || hi_nan), nan_code_ok)

endmodule

bind float32_to_half_pair_pack f2hpp_checker u_f2hpp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .packed_halves_i (out_o.packed_halves)
);

// ----- tb/sv/tb_float32_to_half_pair_pack.sv -----
// testbench for the single-to-half pair packer: predicts each packed word and checks it
module tb_float32_to_half_pair_pack;
  import f2hpp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_PAIRS   = 1600;
  localparam int unsigned STREAM_PAIRS   = 400;
  localparam int unsigned PRESSURE_PAIRS = 30;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned DRAIN_LIMIT    = 1000;
  localparam int unsigned REPORT_LIMIT   = 10;

  logic clk;
  logic rst_n;

  f2hpp_in_if  in_if ();
  f2hpp_out_if out_if ();

  float32_to_half_pair_pack dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [PACK_W-1:0] packed_words_due[$];
  int unsigned       pairs_sent;
  int unsigned       words_checked;
  int unsigned       mismatch_count;
  logic              sender_idles;
  logic              receiver_stalls;
  int unsigned       hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // half-precision conversion: add half an ulp, truncate, saturate specials
  function automatic logic [HALF_W-1:0] half_of_single(input logic [F32_W-1:0] bits);
    logic [7:0]  bexp;
    logic [22:0] frac;
    logic [23:0] sig;
    logic [24:0] rnd;
    int          hexp;
    bexp = bits[30:23];
    frac = bits[22:0];
    if (bexp == F32_EXP_SPECIAL) begin
      if (frac != '0) return HALF_NAN_CODE;
      return {bits[31], HALF_INF_MAG};
    end
    hexp = int'(bexp) - 112;
    if (hexp <= 0) begin
      if (hexp < -10) return {bits[31], 15'h0000};
      sig = {1'b1, frac} >> (1 - hexp);
      rnd = ({1'b0, sig} + 25'h0001000) >> 13;
      if (rnd > 25'(HALF_MANT_MAX)) rnd = 25'(HALF_MANT_MAX);
      return {bits[31], 5'b00000, rnd[9:0]};
    end
    if (hexp >= 31) return {bits[31], HALF_INF_MAG};
    rnd = ({2'b00, frac} + 25'h0001000) >> 13;
    if (rnd > 25'(HALF_MANT_MAX)) begin
      rnd  = '0;
      hexp = hexp + 1;
      if (hexp >= 31) return {bits[31], HALF_INF_MAG};
    end
    return {bits[31], 5'(hexp), rnd[9:0]};
  endfunction

  function automatic logic [PACK_W-1:0] pack_pair(input logic [F32_W-1:0] first_bits,
                                                  input logic [F32_W-1:0] second_bits);
    return {half_of_single(second_bits), half_of_single(first_bits)};
  endfunction

  // append one predicted word at the tail of the queue
  function automatic void queue_expected(input logic [PACK_W-1:0] word);
    packed_words_due = {packed_words_due, word};
  endfunction

  // mostly exponents near the half range, with specials and rounding edges mixed in
  function automatic logic [F32_W-1:0] pick_single();
    logic [F32_W-1:0] v;
    int unsigned      kind;
    v    = $urandom();
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: ;
      2: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      3: v[30:23] = 8'($urandom_range(99, 114));
      4: v[30:23] = 8'($urandom_range(140, 145));
      5: begin
        v[30:23] = 8'($urandom_range(100, 143));
        v[12:0]  = $urandom_range(0, 1) ? 13'h1000 : 13'h0FFF;
      end
      6: begin
        v[30:23] = 8'($urandom_range(100, 143));
        v[22:13] = 10'h3FF;
      end
      default: v[30:23] = 8'($urandom_range(102, 142));
    endcase
    return v;
  endfunction

  function automatic void note_mismatch(input string what, input logic [PACK_W-1:0] want,
                                        input logic [PACK_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s expected %h_%h got %h_%h", $realtime, what,
               want[31:16], want[15:0], got[31:16], got[15:0]);
  endfunction

  task automatic send_pair(input logic [F32_W-1:0] first_bits,
                           input logic [F32_W-1:0] second_bits);
    @(negedge clk);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_if.valid             <= 1'b1;
    in_if.first_float_bits  <= first_bits;
    in_if.second_float_bits <= second_bits;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pairs_sent++;
  endtask

  task automatic finish_sending();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // predicted words are queued on each accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      queue_expected(pack_pair(in_if.first_float_bits, in_if.second_float_bits));
  end

  always @(posedge clk) begin
    logic [PACK_W-1:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (packed_words_due.size() == 0) begin
        note_mismatch("unexpected word", '0, out_if.packed_halves);
      end else begin
        want = packed_words_due.pop_front();
        words_checked++;
        if (out_if.packed_halves !== want) note_mismatch("packed word", want, out_if.packed_halves);
      end
    end
  end

  // receiver: long hold-offs on request, otherwise random stall bursts
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left    = 0;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 6) == 0) begin
        stall_left   = $urandom_range(1, 5) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // zeros, infinities, nans, underflow, overflow, subnormal clamp, ties and rounding carries
  task automatic test_directed_specials();
    send_pair(32'h0000_0000, 32'h8000_0000);
    send_pair(32'h7F80_0000, 32'hFF80_0000);
    send_pair(32'h7FC0_0000, 32'hFF80_0001);
    send_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h0000_0001, 32'h807F_FFFF);
    send_pair(32'h7F7F_FFFF, 32'hFF7F_FFFF);
    send_pair(32'h477F_E000, 32'h477F_F000);
    send_pair(32'h477F_EFFF, 32'hC780_0000);
    send_pair(32'h3300_0000, 32'h32FF_FFFF);
    send_pair(32'hB300_0000, 32'h3380_0000);
    send_pair(32'h387F_FFFF, 32'hB87F_F000);
    send_pair(32'h3880_0000, 32'h3F80_0000);
    send_pair(32'h3F80_1000, 32'h3F80_0FFF);
    send_pair(32'h3FFF_F000, 32'hBF7F_FFFF);
    send_pair(32'h3400_1000, 32'h33FF_FFFF);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure_fill();
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    hold_request    = HOLD_CYCLES;
    for (int i = 0; i < PRESSURE_PAIRS; i++) send_pair(pick_single(), pick_single());
  endtask

  task automatic test_random_traffic(input int unsigned count);
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    for (int i = 0; i < count; i++) send_pair(pick_single(), pick_single());
  endtask

  task automatic test_streaming(input int unsigned count);
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    for (int i = 0; i < count; i++) send_pair(pick_single(), pick_single());
  endtask

  initial begin
    int unsigned waited;
    rst_n                   = 1'b0;
    in_if.valid             = 1'b0;
    in_if.first_float_bits  = '0;
    in_if.second_float_bits = '0;
    sender_idles            = 1'b1;
    receiver_stalls         = 1'b1;
    hold_request            = 0;
    pairs_sent              = 0;
    words_checked           = 0;
    mismatch_count          = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_specials();
    test_backpressure_fill();
    test_random_traffic(RANDOM_PAIRS);
    test_streaming(STREAM_PAIRS);
    finish_sending();

    waited = 0;
    while (packed_words_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    while (packed_words_due.size() != 0)
      note_mismatch("missing word", packed_words_due.pop_front(), '0);

    $display("sent %0d float pairs: signed zeros, infinities, nans, underflow, clamped subnormals,",
             pairs_sent);
    $display("ties, rounding carries and overflow under stalls; %0d packed words checked, %0d bad",
             words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
